// File: rtl/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted table binary search package
// Beat types, operation codes and status codes shared by the search core.
// ---------------------------------------------------------------------------
package stbs_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 7;

   // Operation codes carried by a request beat.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // Status codes carried by a response beat.
   localparam logic [1:0] STATUS_STORED  = 2'd0;
   localparam logic [1:0] STATUS_FOUND   = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [KEY_W-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] position;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/stbs_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Key table memory
// Single write port and single read port with a registered read.
// ---------------------------------------------------------------------------
module stbs_key_ram #(
   parameter int DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [stbs_pkg::KEY_W-1:0]    wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic      [stbs_pkg::KEY_W-1:0]    rd_data
);

   logic [stbs_pkg::KEY_W-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/sorted_table_binary_search_core.sv
// Store and append beats pass through the hold state into the response register,
// and the next beat is accepted only once the core is back in idle. A search
// runs its probes in the read and compare states before the hold state, with at
// most floor(log2(DEPTH)) + 1 probes (7 for 64 entries);
// each probe is a key memory read plus a compare. A stalled response holds the core.
// Reset clears the entry count and control state; the key memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted table binary search core
// Holds a table of signed keys that the user, not the core, keeps ascending, and finds keys by halving.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_core #(
   parameter int DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire stbs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output stbs_pkg::rsp_type      rsp_data
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int BW   = $clog2(DEPTH + 2);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNTW-1:0]            count_ff, count_in;
   logic [BW-1:0]              low_ff, low_in;
   logic [BW-1:0]              high_ff, high_in;
   logic [BW-1:0]              mid_ff, mid_in;
   logic [stbs_pkg::KEY_W-1:0] key_ff, key_in;
   stbs_pkg::rsp_type          res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   stbs_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       has_room;
   logic [BW:0]                bound_sum;
   logic [BW-1:0]              mid_calc;
   logic [BW-1:0]              low_next;
   logic [BW-1:0]              high_next;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [stbs_pkg::KEY_W-1:0] rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign has_room  = (count_ff < CNTW'(DEPTH));

   // Floor midpoint of the 1-based bounds, and the two candidate bounds.
   assign bound_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_calc  = BW'(bound_sum >> 1);
   assign low_next  = mid_ff + BW'(1);
   assign high_next = mid_ff - BW'(1);

   // Memory port control: writes happen at acceptance, reads in the read state.
   assign wr_en   = accept && ((req_data.operation == stbs_pkg::OP_START) ||
                               ((req_data.operation == stbs_pkg::OP_APPEND) && has_room));
   assign wr_addr = (req_data.operation == stbs_pkg::OP_START) ? '0 : AW'(count_ff);
   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = AW'(mid_calc - BW'(1));

   stbs_key_ram #(
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.key_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: decode a request, run the probes, and hand off the result.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = req_data.key_value;
               low_in   = BW'(1);
               high_in  = BW'(count_ff);
               state_in = ST_HOLD;
               priority if (req_data.operation == stbs_pkg::OP_START) begin
                  count_in = CNTW'(1);
                  res_in   = '{status: stbs_pkg::STATUS_STORED,
                               position: stbs_pkg::POS_W'(1)};
               end else if (req_data.operation == stbs_pkg::OP_APPEND) begin
                  if (has_room) begin
                     count_in = count_ff + CNTW'(1);
                     res_in   = '{status: stbs_pkg::STATUS_STORED,
                                  position: stbs_pkg::POS_W'(count_ff + CNTW'(1))};
                  end else begin
                     res_in = '{status: stbs_pkg::STATUS_FULL, position: '0};
                  end
               end else if ((req_data.operation == stbs_pkg::OP_SEARCH) &&
                            (count_ff != '0)) begin
                  state_in = ST_READ;
               end else begin
                  res_in = '{status: stbs_pkg::STATUS_MISSING, position: '0};
               end
            end
         end
         ST_READ: begin
            mid_in   = mid_calc;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            priority if (rd_data == key_ff) begin
               res_in   = '{status: stbs_pkg::STATUS_FOUND,
                            position: stbs_pkg::POS_W'(mid_ff)};
               state_in = ST_HOLD;
            end else if ($signed(rd_data) < $signed(key_ff)) begin
               low_in = low_next;
               if (low_next > high_ff) begin
                  res_in   = '{status: stbs_pkg::STATUS_MISSING, position: '0};
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               high_in = high_next;
               if (low_ff > high_next) begin
                  res_in   = '{status: stbs_pkg::STATUS_MISSING, position: '0};
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      low_ff      <= low_in;
      high_ff     <= high_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// File: tb/sorted_table_binary_search_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted table binary search core testbench
// Drives start, append, search and unused-code beats through the request
// channel, mirrors the key table in a local predictor and compares every
// response beat against the oldest outstanding prediction. A short directed
// plan covers empty, full, extreme and unsorted tables; random tables follow.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_core_test;

   localparam int TABLE_DEPTH     = 64;
   localparam int RESET_CYCLES    = 7;
   localparam int RANDOM_BEATS    = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 3000;
   localparam int END_CYCLES      = 40;

   // The fourth operation code has no function in the core.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [stbs_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [stbs_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam longint KEY_MAX_WIDE = 64'sd2147483647;

   // One line of the directed plan. A row is sent copies times, with the key
   // advancing by key_step; pinned rows carry a fixed expected outcome.
   typedef struct packed {
      logic [1:0]                        operation;
      logic signed [stbs_pkg::KEY_W-1:0] key_value;
      logic [6:0]                        copies;
      logic signed [stbs_pkg::KEY_W-1:0] key_step;
      logic                              pinned;
      stbs_pkg::rsp_type                 outcome;
   } plan_row_type;

   localparam int PLAN_ROWS = 25;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // Search of the empty table after reset, and the unused code.
      '{stbs_pkg::OP_SEARCH, 32'sd0, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{OP_UNUSED, -32'sd1, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      // A table spanning the whole key range.
      '{stbs_pkg::OP_START, KEY_MIN, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd1}},
      '{stbs_pkg::OP_SEARCH, KEY_MIN, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_FOUND, 7'd1}},
      '{stbs_pkg::OP_SEARCH, KEY_MAX, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_APPEND, -32'sd1, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd2}},
      '{stbs_pkg::OP_APPEND, 32'sd0, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd3}},
      '{stbs_pkg::OP_APPEND, KEY_MAX, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd4}},
      '{stbs_pkg::OP_SEARCH, KEY_MAX, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_SEARCH, -32'sd1, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_SEARCH, 32'sd1, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{OP_UNUSED, 32'sd0, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      // A new table filled to capacity, then one append too many.
      '{stbs_pkg::OP_START, -32'sd1000, 7'd1, 32'sd0, 1'b1,
        '{stbs_pkg::STATUS_STORED, 7'd1}},
      '{stbs_pkg::OP_APPEND, -32'sd999, 7'd63, 32'sd1, 1'b0,
        '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_APPEND, 32'sd5, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_FULL, 7'd0}},
      '{stbs_pkg::OP_SEARCH, -32'sd937, 7'd1, 32'sd0, 1'b0,
        '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_SEARCH, -32'sd1000, 7'd1, 32'sd0, 1'b0,
        '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_SEARCH, -32'sd968, 7'd1, 32'sd0, 1'b0,
        '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_SEARCH, 32'sd0, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      // An unsorted table, where halving may miss a stored key.
      '{stbs_pkg::OP_START, 32'sd5, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd1}},
      '{stbs_pkg::OP_APPEND, 32'sd3, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd2}},
      '{stbs_pkg::OP_APPEND, 32'sd1, 7'd1, 32'sd0, 1'b1, '{stbs_pkg::STATUS_STORED, 7'd3}},
      '{stbs_pkg::OP_SEARCH, 32'sd1, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_SEARCH, 32'sd5, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}},
      '{stbs_pkg::OP_APPEND, KEY_MIN, 7'd1, 32'sd0, 1'b0, '{stbs_pkg::STATUS_MISSING, 7'd0}}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   stbs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   stbs_pkg::rsp_type rsp_data;

   // Side information that travels with the request beat being offered.
   logic              req_pinned = 1'b0;
   stbs_pkg::rsp_type req_pinned_outcome = '0;

   // Mirror of the core's key table and the outcomes still owed by it.
   logic signed [stbs_pkg::KEY_W-1:0] mirror_keys [TABLE_DEPTH];
   int                                mirror_count = 0;
   stbs_pkg::rsp_type                 outcomes_due [$];
   stbs_pkg::rsp_type                 oldest_due;
   stbs_pkg::rsp_type                 next_due;

   int mismatch_count = 0;
   int beats_sent = 0;
   int quiet_cycles = 0;
   bit sender_gaps = 1'b1;
   bit hold_off_now = 1'b0;
   logic signed [stbs_pkg::KEY_W-1:0] table_keys [$];

   sorted_table_binary_search_core #(
      .DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // Applies one request beat to the mirrored table and returns the outcome.
   function automatic stbs_pkg::rsp_type expected_outcome(input stbs_pkg::req_type beat);
      stbs_pkg::rsp_type                 outcome;
      logic signed [stbs_pkg::KEY_W-1:0] target;
      int                                low_pos;
      int                                high_pos;
      int                                mid_pos;
      bit                                hit;
      outcome.status = stbs_pkg::STATUS_MISSING;
      outcome.position = '0;
      target = beat.key_value;
      case (beat.operation)
         stbs_pkg::OP_START: begin
            mirror_keys[0] = target;
            mirror_count = 1;
            outcome.status = stbs_pkg::STATUS_STORED;
            outcome.position = stbs_pkg::POS_W'(1);
         end
         stbs_pkg::OP_APPEND: begin
            if (mirror_count < TABLE_DEPTH) begin
               mirror_keys[mirror_count] = target;
               mirror_count++;
               outcome.status = stbs_pkg::STATUS_STORED;
               outcome.position = stbs_pkg::POS_W'(mirror_count);
            end else begin
               outcome.status = stbs_pkg::STATUS_FULL;
            end
         end
         stbs_pkg::OP_SEARCH: begin
            // Halve over 1-based bounds until a match or the bounds cross.
            low_pos = 1;
            high_pos = mirror_count;
            hit = 1'b0;
            while (!hit && low_pos <= high_pos) begin
               mid_pos = (low_pos + high_pos) / 2;
               if (mirror_keys[mid_pos-1] == target) begin
                  hit = 1'b1;
                  outcome.status = stbs_pkg::STATUS_FOUND;
                  outcome.position = stbs_pkg::POS_W'(mid_pos);
               end else if (mirror_keys[mid_pos-1] < target) begin
                  low_pos = mid_pos + 1;
               end else begin
                  high_pos = mid_pos - 1;
               end
            end
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Mostly back-to-back beats, some short gaps and a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!sender_gaps || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request beat and holds it until the core accepts it.
   task automatic send_beat(input logic [1:0] op,
                            input logic signed [stbs_pkg::KEY_W-1:0] key,
                            input logic pinned, input stbs_pkg::rsp_type outcome);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {op, key};
      req_pinned <= pinned;
      req_pinned_outcome <= outcome;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Stops offering beats until every outstanding response has arrived.
   task automatic drain_outcomes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   // Now and then slips in an unused code or an out-of-order append.
   task automatic maybe_noise();
      logic signed [stbs_pkg::KEY_W-1:0] key;
      if ($urandom_range(0, 99) < 5) begin
         key = $urandom;
         if ($urandom_range(0, 1) == 0) begin
            send_beat(OP_UNUSED, key, 1'b0, '0);
         end else begin
            table_keys.push_back(key);
            send_beat(stbs_pkg::OP_APPEND, key, 1'b0, '0);
         end
      end
   endtask

   // Predict at request acceptance; pinned rows override the prediction.
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         next_due = expected_outcome(req_data);
         if (req_pinned) next_due = req_pinned_outcome;
         outcomes_due.push_back(next_due);
      end
   end

   // Compare each response beat with the oldest outstanding outcome.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("unexpected response, status", int'(rsp_data.status), -1);
         end else begin
            oldest_due = outcomes_due.pop_front();
            if (rsp_data.status != oldest_due.status)
               report_mismatch("status", int'(rsp_data.status), int'(oldest_due.status));
            if (rsp_data.position != oldest_due.position)
               report_mismatch("position", int'(rsp_data.position),
                               int'(oldest_due.position));
         end
      end
   end

   // End the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sorted_table_binary_search_core_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: ready stretches, short stalls, rare long stalls and one
   // long hold-off on request.
   initial begin
      int roll;
      int run;
      @(posedge clock);
      forever begin
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(1, 40);
            end else if (roll < 95) begin
               rsp_ready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               run = $urandom_range(10, 40);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   // Request side: reset, the directed plan, then random tables.
   initial begin
      int                                row;
      int                                copy;
      int                                roll;
      int                                appends;
      int                                searches;
      int                                table_index;
      int                                step_bits;
      longint                            next_key;
      logic signed [stbs_pkg::KEY_W-1:0] key;
      plan_row_type                      line;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed plan.
      for (row = 0; row < PLAN_ROWS; row++) begin
         line = DIRECTED_PLAN[row];
         for (copy = 0; copy < line.copies; copy++) begin
            key = line.key_value + copy * line.key_step;
            send_beat(line.operation, key, line.pinned, line.outcome);
         end
      end
      drain_outcomes();

      // Random tables: start, ascending appends, then searches mostly for
      // keys that are present or sit right next to a present key.
      table_index = 0;
      while (beats_sent < RANDOM_BEATS + PLAN_ROWS) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         if (table_index == 4) begin
            hold_off_now = 1'b1;
            sender_gaps = 1'b0;
         end

         roll = $urandom_range(0, 99);
         if (roll < 8) appends = TABLE_DEPTH - 1 + $urandom_range(1, 3);
         else appends = $urandom_range(0, 15);
         searches = $urandom_range(2, 12);

         key = $urandom;
         if ($urandom_range(0, 3) == 0) key = KEY_MIN + $urandom_range(0, 3);
         table_keys.delete();
         table_keys.push_back(key);
         send_beat(stbs_pkg::OP_START, key, 1'b0, '0);

         for (copy = 0; copy < appends; copy++) begin
            maybe_noise();
            step_bits = $urandom_range(0, 30);
            next_key = longint'(key) + longint'($urandom_range(0, 32'd1 << step_bits));
            if (next_key > KEY_MAX_WIDE) next_key = KEY_MAX_WIDE;
            key = next_key[stbs_pkg::KEY_W-1:0];
            table_keys.push_back(key);
            send_beat(stbs_pkg::OP_APPEND, key, 1'b0, '0);
         end

         for (copy = 0; copy < searches; copy++) begin
            maybe_noise();
            roll = $urandom_range(0, 99);
            key = table_keys[$urandom_range(0, table_keys.size() - 1)];
            if (roll >= 95) key = KEY_MAX;
            else if (roll >= 90) key = KEY_MIN;
            else if (roll >= 75) key = $urandom;
            else if (roll >= 65) key = key - 1;
            else if (roll >= 55) key = key + 1;
            send_beat(stbs_pkg::OP_SEARCH, key, 1'b0, '0);
         end

         if (table_index == 2 || $urandom_range(0, 99) < 8) drain_outcomes();
         table_index++;
      end

      drain_outcomes();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sorted_table_binary_search_core_test OK");
      end else begin
         $display("sorted_table_binary_search_core_test NOT OK");
      end
      $finish;
   end

endmodule
